/* rtl/core/pds_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the PLL divider search block.
// No dependencies; imported by pll_divider_search and pds_search.
package pds_pkg;

   // Field widths of frequencies, errors and result codes
   localparam int FREQ_W    = 30;
   localparam int ERR_W     = 32;
   localparam int VCO_W     = FREQ_W + 1;   // VCO never passes 2^31 inside the window scan
   localparam int DEND_W    = FREQ_W + 1;   // reference plus half the divider
   localparam int DIV_SET_W = 5;
   localparam int MUL_SET_W = 9;
   localparam int POST_W    = 2;
   localparam int CSR_IDX_W = 3;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VCO_TARGET  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_MAX     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_TARGET  = 3'd5;

   // Register reset values
   localparam logic [FREQ_W-1:0] RST_VCO_MIN    = 30'd100000000;
   localparam logic [FREQ_W-1:0] RST_VCO_MAX    = 30'd500000000;
   localparam logic [FREQ_W-1:0] RST_VCO_TARGET = 30'd300000000;
   localparam logic [FREQ_W-1:0] RST_DIV_MIN    = 30'd1000000;
   localparam logic [FREQ_W-1:0] RST_DIV_MAX    = 30'd15000000;
   localparam logic [FREQ_W-1:0] RST_DIV_TARGET = 30'd8000000;

   // Post divider codes
   localparam logic [POST_W-1:0] POST_BY1 = 2'd0;
   localparam logic [POST_W-1:0] POST_BY2 = 2'd1;
   localparam logic [POST_W-1:0] POST_BY4 = 2'd3;

   typedef struct packed {
      logic [FREQ_W-1:0] vco_min;
      logic [FREQ_W-1:0] vco_max;
      logic [FREQ_W-1:0] vco_target;
      logic [FREQ_W-1:0] div_min;
      logic [FREQ_W-1:0] div_max;
      logic [FREQ_W-1:0] div_target;
   } cfg_type;

   typedef struct packed {
      logic [DIV_SET_W-1:0] div_setting;
      logic [MUL_SET_W-1:0] mul_setting;
      logic [POST_W-1:0]    post_div_code;
      logic [ERR_W-1:0]     freq_error;
      logic [ERR_W-1:0]     deviation;
      logic                 found;
   } result_type;

endpackage

/* rtl/core/pll_divider_search.sv */
`timescale 1ns / 1ps
// Top level of the PLL divider search: csr registers, handshakes, result register.
// Depends on pds_pkg and pds_search.
//
// Takes a reference and a wanted frequency and returns the input divider,
// multiplier and post divider codes whose output comes closest to the wanted
// frequency, with the error and the tie-break deviation. One request is worked
// on at a time; req_ready is low while a search runs. For each post divider
// setting and each input divider code the block runs a serial division, then,
// if the divided frequency lies in its window, tries one multiplier code per
// cycle until the VCO passes the top of its window or the last code is tried.
// The result word sits in an output register, so the next request can be
// taken while it waits. Registers should be written only while the block is
// idle; csr_ready is always high.
module pll_divider_search #(
   parameter int MUL_CODES         = 512,
   parameter int DIV_CODE_MAX      = 31,
   parameter int POST_DIV_CODE_MAX = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pds_pkg::FREQ_W-1:0]      req_reference_hz,
   input  logic [pds_pkg::FREQ_W-1:0]      req_wanted_hz,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pds_pkg::DIV_SET_W-1:0]   rsp_div_setting,
   output logic [pds_pkg::MUL_SET_W-1:0]   rsp_mul_setting,
   output logic [pds_pkg::POST_W-1:0]      rsp_post_div_code,
   output logic [pds_pkg::ERR_W-1:0]       rsp_freq_error,
   output logic [pds_pkg::ERR_W-1:0]       rsp_deviation,
   output logic                            rsp_found,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pds_pkg::FREQ_W-1:0]      csr_wdata
);
   import pds_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff, rsp_word_in;

   logic       search_idle;
   logic       search_start;
   logic       res_valid;
   logic       res_ready;
   result_type res;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VCO_MIN:    cfg_in.vco_min    = csr_wdata;
            CSR_VCO_MAX:    cfg_in.vco_max    = csr_wdata;
            CSR_VCO_TARGET: cfg_in.vco_target = csr_wdata;
            CSR_DIV_MIN:    cfg_in.div_min    = csr_wdata;
            CSR_DIV_MAX:    cfg_in.div_max    = csr_wdata;
            CSR_DIV_TARGET: cfg_in.div_target = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready    = 1'b1;
   assign req_ready    = search_idle;
   assign search_start = req_valid && search_idle;

   pds_search #(
      .MUL_CODES        (MUL_CODES),
      .DIV_CODE_MAX     (DIV_CODE_MAX),
      .POST_DIV_CODE_MAX(POST_DIV_CODE_MAX)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (search_start),
      .reference_hz(req_reference_hz),
      .wanted_hz   (req_wanted_hz),
      .cfg         (cfg_ff),
      .res_ready   (res_ready),
      .idle        (search_idle),
      .res_valid   (res_valid),
      .res         (res)
   );

   // output register: a new word may load as the old one is taken
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{vco_min:    RST_VCO_MIN,
                           vco_max:    RST_VCO_MAX,
                           vco_target: RST_VCO_TARGET,
                           div_min:    RST_DIV_MIN,
                           div_max:    RST_DIV_MAX,
                           div_target: RST_DIV_TARGET};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_div_setting   = rsp_word_ff.div_setting;
   assign rsp_mul_setting   = rsp_word_ff.mul_setting;
   assign rsp_post_div_code = rsp_word_ff.post_div_code;
   assign rsp_freq_error    = rsp_word_ff.freq_error;
   assign rsp_deviation     = rsp_word_ff.deviation;
   assign rsp_found         = rsp_word_ff.found;

endmodule

/* rtl/core/pds_divider.sv */
`timescale 1ns / 1ps
// Serial restoring divider: one quotient bit per cycle.
// Standalone; used by pds_search for the divided reference frequency.
module pds_divider #(
   parameter int DEND_W = 31,
   parameter int DSOR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DEND_W-1:0] dividend,
   input  logic [DSOR_W-1:0] divisor,
   output logic              done,
   output logic [DEND_W-1:0] quotient
);

   localparam int CW = (DEND_W < 2) ? 1 : $clog2(DEND_W);
   localparam logic [CW-1:0] CNT_LAST = CW'(DEND_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DSOR_W-1:0] rem_ff, rem_in;
   logic [DEND_W-1:0] quo_ff, quo_in;
   logic [DSOR_W:0]   shifted;
   logic              fits;

   // one restoring step: shift in the next dividend bit, try to subtract
   assign shifted = {rem_ff, quo_ff[DEND_W-1]};
   assign fits    = (shifted >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DSOR_W'(shifted - {1'b0, divisor}) : shifted[DSOR_W-1:0];
         quo_in = {quo_ff[DEND_W-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/pds_search.sv */
`timescale 1ns / 1ps
// Search sequencer and candidate pipeline of the PLL divider search.
// Depends on pds_pkg and pds_divider.
module pds_search #(
   parameter int MUL_CODES         = 512,
   parameter int DIV_CODE_MAX      = 31,
   parameter int POST_DIV_CODE_MAX = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pds_pkg::FREQ_W-1:0]    reference_hz,
   input  logic [pds_pkg::FREQ_W-1:0]    wanted_hz,
   input  pds_pkg::cfg_type              cfg,
   input  logic                          res_ready,
   output logic                          idle,
   output logic                          res_valid,
   output pds_pkg::result_type           res
);
   import pds_pkg::*;

   localparam int DSOR_W = $clog2(DIV_CODE_MAX + 3);
   localparam int NW     = $clog2(DIV_CODE_MAX + 1);
   localparam int MW     = $clog2(MUL_CODES);
   localparam int DCW    = (POST_DIV_CODE_MAX < 1) ? 1 : $clog2(POST_DIV_CODE_MAX + 1);

   localparam logic [NW-1:0]  N_LAST = NW'(DIV_CODE_MAX);
   localparam logic [MW-1:0]  M_LAST = MW'(MUL_CODES - 1);
   localparam logic [DCW-1:0] D_LAST = DCW'(POST_DIV_CODE_MAX);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DIV_START = 3'd1;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
   localparam logic [2:0] ST_N_CHECK   = 3'd3;
   localparam logic [2:0] ST_M_LOOP    = 3'd4;
   localparam logic [2:0] ST_NEXT_N    = 3'd5;
   localparam logic [2:0] ST_NEXT_D    = 3'd6;
   localparam logic [2:0] ST_DONE      = 3'd7;

   typedef struct packed {
      logic [NW-1:0]  n;
      logic [MW-1:0]  m;
      logic [DCW-1:0] d;
   } code_type;

   logic [2:0]        state_ff, state_in;
   logic [FREQ_W-1:0] ref_ff, ref_in;
   logic [FREQ_W-1:0] want_ff, want_in;
   logic [DCW-1:0]    d_ff, d_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [MW-1:0]     m_ff, m_in;
   logic [FREQ_W-1:0] dfreq_ff, dfreq_in;
   logic [FREQ_W-1:0] ddiv_ff, ddiv_in;
   logic [VCO_W-1:0]  vco_ff, vco_in;

   // stage 1 -> 2: rounded output frequency and VCO
   logic              p1_valid_ff, p1_valid_in;
   logic [ERR_W-1:0]  p1_outf_ff, p1_outf_in;
   logic [VCO_W-1:0]  p1_vco_ff, p1_vco_in;
   code_type          p1_code_ff, p1_code_in;
   // stage 2 -> 3: error and VCO distance
   logic              p2_valid_ff, p2_valid_in;
   logic [ERR_W-1:0]  p2_err_ff, p2_err_in;
   logic [VCO_W-1:0]  p2_dvco_ff, p2_dvco_in;
   code_type          p2_code_ff, p2_code_in;
   // best so far
   logic              found_ff, found_in;
   logic [ERR_W-1:0]  best_err_ff, best_err_in;
   logic [ERR_W-1:0]  best_dev_ff, best_dev_in;
   code_type          best_code_ff, best_code_in;

   logic              div_start, div_done;
   logic [DSOR_W-1:0] divisor;
   logic [DEND_W-1:0] dividend;
   logic [DEND_W-1:0] quotient;
   logic              vco_below, vco_above;
   logic [ERR_W-1:0]  rnd_sum;
   logic [ERR_W-1:0]  want_x;
   logic [VCO_W-1:0]  vtgt_x;
   logic [ERR_W-1:0]  cand_dev;
   logic              better;

   // divider by n+2 with round to nearest
   assign divisor  = DSOR_W'(n_ff) + DSOR_W'(2);
   assign dividend = {1'b0, ref_ff} + DEND_W'(divisor >> 1);

   pds_divider #(
      .DEND_W(DEND_W),
      .DSOR_W(DSOR_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(dividend),
      .divisor (divisor),
      .done    (div_done),
      .quotient(quotient)
   );

   // stage 1: window checks and post divider rounding
   assign vco_below = (vco_ff < VCO_W'(cfg.vco_min));
   assign vco_above = (vco_ff > VCO_W'(cfg.vco_max));
   assign rnd_sum   = ERR_W'(vco_ff) + ((ERR_W'(1) << d_ff) >> 1);

   // stage 2 operands
   assign want_x = ERR_W'(want_ff);
   assign vtgt_x = VCO_W'(cfg.vco_target);

   // stage 3: deviation and best compare
   assign cand_dev = ERR_W'(p2_dvco_ff) + ERR_W'(ddiv_ff);
   assign better   = !found_ff || (p2_err_ff < best_err_ff) ||
                     ((p2_err_ff == best_err_ff) && (cand_dev < best_dev_ff));

   always_comb begin
      state_in     = state_ff;
      ref_in       = ref_ff;
      want_in      = want_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      dfreq_in     = dfreq_ff;
      ddiv_in      = ddiv_ff;
      vco_in       = vco_ff;
      found_in     = found_ff;
      best_err_in  = best_err_ff;
      best_dev_in  = best_dev_ff;
      best_code_in = best_code_ff;
      div_start    = 1'b0;
      res_valid    = 1'b0;

      p1_valid_in  = 1'b0;
      p1_outf_in   = rnd_sum >> d_ff;
      p1_vco_in    = vco_ff;
      p1_code_in   = '{n: n_ff, m: m_ff, d: d_ff};

      p2_valid_in  = p1_valid_ff;
      p2_err_in    = (p1_outf_ff >= want_x) ? (p1_outf_ff - want_x) : (want_x - p1_outf_ff);
      p2_dvco_in   = (p1_vco_ff >= vtgt_x) ? (p1_vco_ff - vtgt_x) : (vtgt_x - p1_vco_ff);
      p2_code_in   = p1_code_ff;

      // keep the best candidate; full ties keep the earlier one
      if (p2_valid_ff && better) begin
         found_in     = 1'b1;
         best_err_in  = p2_err_ff;
         best_dev_in  = cand_dev;
         best_code_in = p2_code_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ref_in       = reference_hz;
               want_in      = wanted_hz;
               d_in         = '0;
               n_in         = N_LAST;
               found_in     = 1'b0;
               best_err_in  = '1;
               best_dev_in  = '1;
               best_code_in = '0;
               state_in     = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               dfreq_in = quotient[FREQ_W-1:0];
               state_in = ST_N_CHECK;
            end
         end
         ST_N_CHECK: begin
            // low test first: below skips this n, above ends the n scan
            if (dfreq_ff < cfg.div_min) begin
               state_in = ST_NEXT_N;
            end else if (dfreq_ff > cfg.div_max) begin
               state_in = ST_NEXT_D;
            end else begin
               vco_in   = {dfreq_ff, 1'b0};
               m_in     = '0;
               ddiv_in  = (dfreq_ff >= cfg.div_target) ? (dfreq_ff - cfg.div_target)
                                                       : (cfg.div_target - dfreq_ff);
               state_in = ST_M_LOOP;
            end
         end
         ST_M_LOOP: begin
            // one multiplier code per cycle, VCO stepped by the divided frequency
            if (vco_above) begin
               state_in = ST_NEXT_N;
            end else begin
               p1_valid_in = !vco_below;
               vco_in      = vco_ff + VCO_W'(dfreq_ff);
               if (m_ff == M_LAST) begin
                  state_in = ST_NEXT_N;
               end else begin
                  m_in = m_ff + MW'(1);
               end
            end
         end
         ST_NEXT_N: begin
            if (n_ff == '0) begin
               state_in = ST_NEXT_D;
            end else begin
               n_in     = n_ff - NW'(1);
               state_in = ST_DIV_START;
            end
         end
         ST_NEXT_D: begin
            if (d_ff == D_LAST) begin
               state_in = ST_DONE;
            end else begin
               d_in     = d_ff + DCW'(1);
               n_in     = N_LAST;
               state_in = ST_DIV_START;
            end
         end
         ST_DONE: begin
            // pipeline has drained by now; hand the word over when there is room
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         found_ff    <= found_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      ref_ff       <= ref_in;
      want_ff      <= want_in;
      d_ff         <= d_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      dfreq_ff     <= dfreq_in;
      ddiv_ff      <= ddiv_in;
      vco_ff       <= vco_in;
      p1_outf_ff   <= p1_outf_in;
      p1_vco_ff    <= p1_vco_in;
      p1_code_ff   <= p1_code_in;
      p2_err_ff    <= p2_err_in;
      p2_dvco_ff   <= p2_dvco_in;
      p2_code_ff   <= p2_code_in;
      best_err_ff  <= best_err_in;
      best_dev_ff  <= best_dev_in;
      best_code_ff <= best_code_in;
   end

   // result word
   always_comb begin
      res.div_setting = DIV_SET_W'(best_code_ff.n);
      res.mul_setting = MUL_SET_W'(best_code_ff.m);
      if (best_code_ff.d == '0) begin
         res.post_div_code = POST_BY1;
      end else if (best_code_ff.d == DCW'(1)) begin
         res.post_div_code = POST_BY2;
      end else begin
         res.post_div_code = POST_BY4;
      end
      res.freq_error = best_err_ff;
      res.deviation  = best_dev_ff;
      res.found      = found_ff;
   end

   assign idle = (state_ff == ST_IDLE);

endmodule
